// ----- rtl/core/bfi_pkg.sv -----
// Package for the bloom filter insert block.
// Holds the store geometry, register indexes and field widths.
// No dependencies; every other file of the block but bfi_ram uses it.
package bfi_pkg;

  localparam int FILTER_BITS  = 2048;
  localparam int WORD_BITS    = 64;
  localparam int FILTER_WORDS = (FILTER_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW      = $clog2(FILTER_WORDS);
  localparam int BIT_AW       = $clog2(WORD_BITS);
  localparam int POS_W        = $clog2(FILTER_BITS);
  localparam int MAX_HASHES   = 8;

  localparam int HASH_W   = 64;
  localparam int ONES_W   = 12;
  localparam int INSERT_W = 16;
  localparam int CNT_W    = 4;
  localparam int IBITS_W  = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ELEMENTS = 2'd2;

  localparam logic [CNT_W-1:0]    NUM_HASHES_RST   = 4'd5;
  localparam logic [IBITS_W-1:0]  INDEX_BITS_RST   = 4'd11;
  localparam logic [INSERT_W-1:0] MAX_ELEMENTS_RST = 16'd160;

endpackage

// ----- rtl/core/bfi_in_if.sv -----
// Input channel of the bloom filter insert block: one hash per item.
// Depends on bfi_pkg for the field width.
interface bfi_in_if;
  logic                          valid;
  logic                          ready;
  logic [bfi_pkg::HASH_W-1:0]    hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

// ----- rtl/core/bfi_out_if.sv -----
// Result channel of the bloom filter insert block: counts and overfull flag.
// Depends on bfi_pkg for the field widths.
interface bfi_out_if;
  logic                          valid;
  logic                          ready;
  logic [bfi_pkg::ONES_W-1:0]    bits_set_count;
  logic [bfi_pkg::INSERT_W-1:0]  insert_count;
  logic                          overfull;

  modport source (output valid, output bits_set_count, output insert_count,
                  output overfull, input ready);
  modport sink   (input valid, input bits_set_count, input insert_count,
                  input overfull, output ready);
endinterface

// ----- rtl/core/bfi_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bfi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/bloom_filter_insert_top.sv -----
// Top level of the bloom filter insert block.
// Depends on bfi_pkg, bfi_in_if, bfi_out_if and bfi_ram.
//
// Usage:
//   in_ch carries one 64-bit hash per item. The block cuts num_hashes slices
//   of index_bits bits from it, starting at bit 0, and sets one bit of a
//   2048-bit filter store per slice. out_ch returns one item per insert: the
//   count of set bits, the saturating insert count and the overfull flag.
//   The cfg_ port writes num_hashes, index_bits and max_elements; write it
//   only while the block is idle.
// Sequence:
//   Each slice is a read-modify-write of one 64-bit word over the store's
//   read and write ports: a read state, then a write state. An insert with n
//   slices (n = num_hashes clamped to 8) runs n such pairs and then a finish
//   state, where its result is registered; in_ch.ready is low meanwhile. The
//   next item is accepted only once the block is back in idle.
// Reset and stalls:
//   Reset restores the register defaults, zeroes both counts and marks all
//   32 store words invalid, so they read as zero with no clearing pass.
//   A result waits in the output register while out_ch.ready is low; the
//   next item is still accepted, and its result waits until that one leaves.
module bloom_filter_insert_top (
  input  logic                             clk,
  input  logic                             rst_n,
  bfi_in_if.sink                           in_ch,
  bfi_out_if.source                        out_ch,
  input  logic                             cfg_wr_en,
  input  logic [bfi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfi_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_FINISH
  } state_t;

  state_t state_r;

  logic [bfi_pkg::CNT_W-1:0]     num_hashes_r;
  logic [bfi_pkg::IBITS_W-1:0]   index_bits_r;
  logic [bfi_pkg::INSERT_W-1:0]  max_elements_r;

  logic [bfi_pkg::HASH_W-1:0]    hash_r;
  logic [bfi_pkg::CNT_W-1:0]     left_r;
  logic                          full_r;
  logic [bfi_pkg::WORD_AW-1:0]   word_r;
  logic [bfi_pkg::BIT_AW-1:0]    bit_r;
  logic [bfi_pkg::FILTER_WORDS-1:0] valid_r;
  logic [bfi_pkg::INSERT_W-1:0]  inserts_r;
  logic [bfi_pkg::ONES_W-1:0]    ones_r;

  logic                          out_valid_r;
  logic [bfi_pkg::ONES_W-1:0]    out_ones_r;
  logic [bfi_pkg::INSERT_W-1:0]  out_inserts_r;
  logic                          out_full_r;

  logic [bfi_pkg::CNT_W-1:0]     clamped_cnt;
  logic [bfi_pkg::POS_W-1:0]     idx_mask;
  logic [bfi_pkg::POS_W-1:0]     slice_pos;
  logic [bfi_pkg::WORD_BITS-1:0] rd_data;
  logic [bfi_pkg::WORD_BITS-1:0] old_word;
  logic [bfi_pkg::WORD_BITS-1:0] bit_onehot;
  logic                          ram_we;
  logic [bfi_pkg::INSERT_W-1:0]  inserts_nxt;
  logic                          out_free;

  assign clamped_cnt = (num_hashes_r > bfi_pkg::CNT_W'(bfi_pkg::MAX_HASHES))
                     ? bfi_pkg::CNT_W'(bfi_pkg::MAX_HASHES) : num_hashes_r;

  // Only the low bits of a slice survive the modulo by the store size.
  assign idx_mask = (index_bits_r >= bfi_pkg::IBITS_W'(bfi_pkg::POS_W))
                  ? '1 : ((bfi_pkg::POS_W'(1) << index_bits_r) - bfi_pkg::POS_W'(1));
  assign slice_pos = hash_r[bfi_pkg::POS_W-1:0] & idx_mask;

  assign old_word   = valid_r[word_r] ? rd_data : '0;
  assign bit_onehot = bfi_pkg::WORD_BITS'(1) << bit_r;
  assign ram_we     = (state_r == ST_WRITE) && !old_word[bit_r];

  assign inserts_nxt = (inserts_r == '1) ? inserts_r : inserts_r + 1'b1;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.bits_set_count = out_ones_r;
  assign out_ch.insert_count   = out_inserts_r;
  assign out_ch.overfull       = out_full_r;

  bfi_ram #(
    .WIDTH (bfi_pkg::WORD_BITS),
    .DEPTH (bfi_pkg::FILTER_WORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (word_r),
    .wr_data (old_word | bit_onehot),
    .rd_addr (slice_pos[bfi_pkg::POS_W-1:bfi_pkg::BIT_AW]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_hashes_r   <= bfi_pkg::NUM_HASHES_RST;
      index_bits_r   <= bfi_pkg::INDEX_BITS_RST;
      max_elements_r <= bfi_pkg::MAX_ELEMENTS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bfi_pkg::CFG_NUM_HASHES:   num_hashes_r   <= cfg_wdata[bfi_pkg::CNT_W-1:0];
        bfi_pkg::CFG_INDEX_BITS:   index_bits_r   <= cfg_wdata[bfi_pkg::IBITS_W-1:0];
        bfi_pkg::CFG_MAX_ELEMENTS: max_elements_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      inserts_r   <= '0;
      ones_r      <= '0;
      out_valid_r <= 1'b0;
      left_r      <= '0;
    end else begin
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            hash_r  <= in_ch.hash_value;
            left_r  <= clamped_cnt;
            full_r  <= (inserts_r >= max_elements_r);
            state_r <= (clamped_cnt == '0) ? ST_FINISH : ST_READ;
          end
        end
        ST_READ: begin
          word_r  <= slice_pos[bfi_pkg::POS_W-1:bfi_pkg::BIT_AW];
          bit_r   <= slice_pos[bfi_pkg::BIT_AW-1:0];
          state_r <= ST_WRITE;
        end
        ST_WRITE: begin
          if (ram_we) begin
            valid_r[word_r] <= 1'b1;
            if (ones_r != '1) begin
              ones_r <= ones_r + 1'b1;
            end
          end
          hash_r  <= hash_r >> index_bits_r;
          left_r  <= left_r - 1'b1;
          state_r <= (left_r == bfi_pkg::CNT_W'(1)) ? ST_FINISH : ST_READ;
        end
        ST_FINISH: begin
          if (out_free) begin
            inserts_r     <= inserts_nxt;
            out_ones_r    <= ones_r;
            out_inserts_r <= inserts_nxt;
            out_full_r    <= full_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/bloom_filter_insert_top_test.sv -----
// Self-checking testbench for bloom_filter_insert_top: directed and random hashes under bursty
// input and a patterned output stall, checked against a local model of the store and counters.
// Depends on bfi_pkg, bfi_in_if, bfi_out_if and the block's RTL.
`timescale 1ns / 100ps

module bloom_filter_insert_top_test;

  localparam logic [bfi_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 24;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [bfi_pkg::ONES_W-1:0]   bits_set_count;
    logic [bfi_pkg::INSERT_W-1:0] insert_count;
    logic                         overfull;
  } tally_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [bfi_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bfi_pkg::CFG_DATA_W-1:0] cfg_wdata;

  bfi_in_if  in_ch ();
  bfi_out_if out_ch ();

  bloom_filter_insert_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Local copy of the block's state and registers.
  bit [bfi_pkg::FILTER_BITS-1:0]  filter_map;
  int unsigned                    inserts_seen;
  int unsigned                    ones_seen;
  logic [bfi_pkg::CNT_W-1:0]      hashes_reg;
  logic [bfi_pkg::IBITS_W-1:0]    slice_width_reg;
  logic [bfi_pkg::INSERT_W-1:0]   full_mark_reg;

  logic [bfi_pkg::HASH_W-1:0] pending_hashes[$];
  tally_t                     expected_tallies[$];
  int                         error_count = 0;

  int burst_left = 1;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_mode_left = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int idle_cycles = 0;

  task automatic report_mismatch(input string msg);
    // Only the first few are printed so that a broken block cannot flood the log.
    if (error_count < PRINT_LIMIT) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    error_count++;
  endtask

  function automatic void add_hash(input logic [bfi_pkg::HASH_W-1:0] hash);
    pending_hashes = {pending_hashes, hash};
  endfunction

  // Sets the filter bits for one hash and queues the tally the block should return.
  function automatic void insert_hash(input logic [bfi_pkg::HASH_W-1:0] hash);
    int unsigned slices;
    int unsigned start;
    int unsigned pos;
    logic [bfi_pkg::HASH_W-1:0] mask;
    tally_t t;
    slices = (hashes_reg > bfi_pkg::MAX_HASHES) ? bfi_pkg::MAX_HASHES : hashes_reg;
    t.overfull = (inserts_seen >= full_mark_reg);
    mask = (64'd1 << slice_width_reg) - 64'd1;
    for (int i = 0; i < slices; i++) begin
      start = slice_width_reg * i;
      // A slice starting past the top bit reads as zero; a partial one is zero-filled.
      if (start >= bfi_pkg::HASH_W) pos = 0;
      else pos = int'((hash >> start) & mask);
      pos = pos % bfi_pkg::FILTER_BITS;
      if (!filter_map[pos]) begin
        filter_map[pos] = 1'b1;
        if (ones_seen < 4095) ones_seen++;
      end
    end
    if (inserts_seen < 65535) inserts_seen++;
    t.bits_set_count = ones_seen[bfi_pkg::ONES_W-1:0];
    t.insert_count = inserts_seen[bfi_pkg::INSERT_W-1:0];
    expected_tallies = {expected_tallies, t};
  endfunction

  function automatic logic [bfi_pkg::HASH_W-1:0] random_hash();
    logic [bfi_pkg::HASH_W-1:0] a;
    logic [bfi_pkg::HASH_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: random_hash = 64'd1 << $urandom_range(0, 63);
      1: random_hash = a & b & {$urandom, $urandom};
      2: random_hash = a | b;
      default: random_hash = a;
    endcase
  endfunction

  // Driver: bursts of items separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) insert_hash(in_ch.hash_value);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_hashes.size() != 0) begin
          in_ch.valid <= 1'b1;
          in_ch.hash_value <= pending_hashes.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: the stall pattern is redrawn at random among four modes when its mode counter runs out.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_mode_left <= $urandom_range(30, 200);
      end else begin
        stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        2: begin
          if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 40);
          end
        end
        default: out_ch.ready <= (cycle_count % 3 == 0);
      endcase
    end
  end

  // Monitor: every result item is checked against the oldest expected tally.
  always @(posedge clk) begin : monitor
    tally_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_tallies.size() == 0) begin
        report_mismatch("result item with no insert outstanding");
      end else begin
        want = expected_tallies.pop_front();
        if (out_ch.bits_set_count !== want.bits_set_count)
          report_mismatch($sformatf("bits_set_count got %0d want %0d",
                                    out_ch.bits_set_count, want.bits_set_count));
        if (out_ch.insert_count !== want.insert_count)
          report_mismatch($sformatf("insert_count got %0d want %0d",
                                    out_ch.insert_count, want.insert_count));
        if (out_ch.overfull !== want.overfull)
          report_mismatch($sformatf("overfull got %0b want %0b",
                                    out_ch.overfull, want.overfull));
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Waits until every queued item has gone in and every result has come out.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_hashes.size() != 0 || in_ch.valid || expected_tallies.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [bfi_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bfi_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      bfi_pkg::CFG_NUM_HASHES:   hashes_reg = data[bfi_pkg::CNT_W-1:0];
      bfi_pkg::CFG_INDEX_BITS:   slice_width_reg = data[bfi_pkg::IBITS_W-1:0];
      bfi_pkg::CFG_MAX_ELEMENTS: full_mark_reg = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Upper data bits of the narrow registers are random; the block must drop them.
  task automatic set_config(input int unsigned nh, input int unsigned ib, input int unsigned mx);
    wait_drained();
    cfg_write(bfi_pkg::CFG_NUM_HASHES, {12'($urandom), 4'(nh)});
    cfg_write(bfi_pkg::CFG_INDEX_BITS, {12'($urandom), 4'(ib)});
    cfg_write(bfi_pkg::CFG_MAX_ELEMENTS, 16'(mx));
    cfg_write(CFG_UNUSED, 16'($urandom));
    @(negedge clk);
  endtask

  task automatic queue_random(input int unsigned count);
    for (int i = 0; i < count; i++) add_hash(random_hash());
  endtask

  initial begin
    int unsigned ib;
    int unsigned nh;
    int unsigned mx;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = bfi_pkg::CFG_NUM_HASHES;
    cfg_wdata = '0;
    filter_map = '0;
    inserts_seen = 0;
    ones_seen = 0;
    hashes_reg = bfi_pkg::NUM_HASHES_RST;
    slice_width_reg = bfi_pkg::INDEX_BITS_RST;
    full_mark_reg = bfi_pkg::MAX_ELEMENTS_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, starting from the reset values of the registers.
    @(negedge clk);
    add_hash(64'h0);
    add_hash('1);
    add_hash(64'haaaa_aaaa_aaaa_aaaa);
    add_hash(64'h5555_5555_5555_5555);
    add_hash(64'h8000_0000_0000_0000);
    add_hash(64'h0123_4567_89ab_cdef);
    // Eight slices of eleven bits: the sixth runs past the top bit, the last two start past it.
    set_config(8, 11, 160);
    add_hash('1);
    add_hash(64'hffe0_0000_0000_0001);
    add_hash(64'h8000_0000_0000_0001);
    // Clamped slice count, indexes wider than the store, full from the first insert.
    set_config(15, 15, 0);
    add_hash('1);
    add_hash(64'h0000_0000_0000_7fff);
    queue_random(1);
    // No slices at all, then zero-width slices that all hit bit 0.
    set_config(0, 0, 65535);
    queue_random(2);
    set_config(3, 0, 65535);
    queue_random(2);
    // The second insert here is the first one to arrive with the filter full.
    wait_drained();
    set_config(1, 1, inserts_seen + 1);
    queue_random(3);

    // Random part: slices widen phase by phase so the store fills gradually.
    for (int p = 0; p < 12; p++) begin
      ib = (p < 11) ? p + 1 : $urandom_range(12, 15);
      case (p)
        3: nh = 1;
        5: nh = 8;
        7: nh = 15;
        9: nh = 0;
        default: nh = $urandom_range(0, 15);
      endcase
      wait_drained();
      case ($urandom_range(0, 3))
        0: mx = 0;
        1: mx = 65535;
        default: mx = inserts_seen + $urandom_range(0, 120);
      endcase
      set_config(nh, ib, mx);
      queue_random(117);
    end

    set_config(8, 11, 65535);
    queue_random(20);
    set_config(2, 13, 0);
    queue_random(10);

    wait_drained();
    if (expected_tallies.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_tallies.size()));
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- bloom_filter_insert_top.f -----
rtl/core/bfi_pkg.sv
rtl/core/bfi_in_if.sv
rtl/core/bfi_out_if.sv
rtl/core/bfi_ram.sv
rtl/core/bloom_filter_insert_top.sv
tb/bloom_filter_insert_top_test.sv
